/* rtl/ppt_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// permutation power transposer. No dependencies.
package ppt_pkg;

   localparam int MAX_SIZE = 256;
   localparam int POS_W    = 8;
   localparam int SIZE_W   = 9;
   localparam int COUNT_W  = 31;
   localparam int DIV_STEPS = COUNT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_ENCODE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK1,
      ST_MOD,
      ST_WALK2,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic walk1_step;
      logic mod_start;
      logic set_bad;
      logic dest_home;
      logic walk2_start;
      logic walk2_step;
      logic dest_take;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic pos_oor;
      logic step_bad;
      logic step_home;
      logic mod_done;
      logic rem_zero;
      logic count_last;
      logic out_free;
   } status_type;

endpackage

/* rtl/ppt_modulo.sv */
// Bit-serial restoring remainder unit: repeat count modulo cycle length.
// Depends on ppt_pkg.
module ppt_modulo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ppt_pkg::COUNT_W-1:0]     dividend,
   input  logic [ppt_pkg::SIZE_W-1:0]      divisor,
   output logic                            done,
   output logic [ppt_pkg::POS_W-1:0]       remainder
);
   import ppt_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COUNT_W-1:0]    num_ff, num_in;
   logic [SIZE_W-1:0]     div_ff, div_in;
   logic [SIZE_W-1:0]     rem_ff, rem_in;
   logic [SIZE_W:0]       trial;

   assign trial = {rem_ff, num_ff[COUNT_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[COUNT_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = SIZE_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[SIZE_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[POS_W-1:0];

endmodule

/* rtl/ppt_datapath.sv */
// Datapath: permutation table, size register, walk registers, remainder unit
// and result register. Depends on ppt_pkg and ppt_modulo.
module ppt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  ppt_pkg::cmd_type                cmd,
   output ppt_pkg::status_type             status,
   input  logic                            csr_valid,
   input  logic [ppt_pkg::SIZE_W-1:0]      csr_size_in_use,
   input  logic                            req_action,
   input  logic [ppt_pkg::POS_W-1:0]       req_position,
   input  logic [ppt_pkg::POS_W-1:0]       req_target,
   input  logic [ppt_pkg::POS_W-1:0]       req_symbol,
   input  logic [ppt_pkg::COUNT_W-1:0]     req_repeat_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ppt_pkg::POS_W-1:0]       rsp_destination,
   output logic [ppt_pkg::POS_W-1:0]       rsp_symbol_out,
   output logic                            rsp_bad_table
);
   import ppt_pkg::*;

   logic [POS_W-1:0]    table_ff [MAX_SIZE];
   logic [POS_W-1:0]    rd_ff;
   logic [POS_W-1:0]    rd_addr;
   logic                rd_en;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    sym_ff;
   logic [COUNT_W-1:0]  k_ff;
   logic                pos_oor_ff;
   logic [SIZE_W-1:0]   len_ff;
   logic [SIZE_W-1:0]   len_next;
   logic [POS_W-1:0]    count_ff;
   logic [POS_W-1:0]    dest_ff;
   logic                bad_ff;
   logic                rsp_valid_ff;
   logic [POS_W-1:0]    rsp_dest_ff;
   logic [POS_W-1:0]    rsp_sym_ff;
   logic                rsp_bad_ff;
   logic                mod_done;
   logic [POS_W-1:0]    mod_rem;

   // clamp size to 1..MAX_SIZE
   always_comb begin
      if (csr_size_in_use == '0) begin
         size_in = SIZE_W'(1);
      end else if (csr_size_in_use > SIZE_W'(MAX_SIZE)) begin
         size_in = SIZE_W'(MAX_SIZE);
      end else begin
         size_in = csr_size_in_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(MAX_SIZE);
      end else if (csr_valid) begin
         size_ff <= size_in;
      end
   end

   assign len_next = len_ff + 1'b1;

   always_comb begin
      if (cmd.capture) begin
         rd_addr = req_position;
      end else if (cmd.walk2_start) begin
         rd_addr = pos_ff;
      end else begin
         rd_addr = rd_ff;
      end
   end

   assign rd_en = cmd.capture | cmd.walk1_step | cmd.walk2_start | cmd.walk2_step;

   always_ff @(posedge clock) begin
      if (cmd.capture && (req_action == ACT_LOAD) && ({1'b0, req_position} < size_ff)) begin
         table_ff[req_position] <= req_target;
      end
      if (rd_en) begin
         rd_ff <= table_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_ff     <= req_position;
         sym_ff     <= req_symbol;
         k_ff       <= req_repeat_count;
         pos_oor_ff <= {1'b0, req_position} >= size_ff;
         len_ff     <= '0;
      end
      if (cmd.walk1_step) begin
         len_ff <= len_next;
      end
      if (cmd.walk2_start) begin
         count_ff <= mod_rem;
      end else if (cmd.walk2_step) begin
         count_ff <= count_ff - 1'b1;
      end
      if (cmd.set_bad) begin
         dest_ff <= '0;
         bad_ff  <= 1'b1;
      end else if (cmd.dest_home) begin
         dest_ff <= pos_ff;
         bad_ff  <= 1'b0;
      end else if (cmd.dest_take) begin
         dest_ff <= rd_ff;
         bad_ff  <= 1'b0;
      end
   end

   ppt_modulo u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (k_ff),
      .divisor   (len_next),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.publish) begin
         rsp_dest_ff <= dest_ff;
         rsp_sym_ff  <= sym_ff;
         rsp_bad_ff  <= bad_ff;
      end
   end

   always_comb begin
      status.pos_oor    = pos_oor_ff;
      status.step_bad   = ({1'b0, rd_ff} >= size_ff) ||
                          ((rd_ff != pos_ff) && (len_next == size_ff));
      status.step_home  = rd_ff == pos_ff;
      status.mod_done   = mod_done;
      status.rem_zero   = mod_rem == '0;
      status.count_last = count_ff == POS_W'(1);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_destination = rsp_dest_ff;
   assign rsp_symbol_out  = rsp_sym_ff;
   assign rsp_bad_table   = rsp_bad_ff;

   a_bad_means_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_dest_ff == '0)
      else $error("bad result with nonzero destination");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten");

   a_walk2_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.walk2_step |-> {1'b0, rd_ff} < size_ff)
      else $error("second walk left the block");

endmodule

/* rtl/ppt_ctrl.sv */
// Controller state machine: sequences load, cycle walk, remainder and
// second walk. Depends on ppt_pkg.
module ppt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_action,
   output logic                  req_ready,
   input  ppt_pkg::status_type   status,
   output ppt_pkg::cmd_type      cmd
);
   import ppt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_action == ACT_ENCODE)) begin
               state_in = ST_WALK1;
            end
         end
         ST_WALK1: begin
            if (status.pos_oor || status.step_bad) begin
               state_in = ST_FINISH;
            end else if (status.step_home) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (status.mod_done) begin
               state_in = status.rem_zero ? ST_FINISH : ST_WALK2;
            end
         end
         ST_WALK2: begin
            if (status.count_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_WALK1: begin
            if (status.pos_oor || status.step_bad) begin
               cmd.set_bad = 1'b1;
            end else if (status.step_home) begin
               cmd.mod_start = 1'b1;
            end else begin
               cmd.walk1_step = 1'b1;
            end
         end
         ST_MOD: begin
            if (status.mod_done) begin
               cmd.dest_home   = status.rem_zero;
               cmd.walk2_start = !status.rem_zero;
            end
         end
         ST_WALK2: begin
            cmd.dest_take  = status.count_last;
            cmd.walk2_step = !status.count_last;
         end
         ST_FINISH: begin
            cmd.publish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/permutation_power_transposer.sv */
// Permutation power transposer: a load item stores one permutation entry;
// an encode item returns the position reached after applying the
// permutation repeat_count times, with the symbol passed through. An
// encode captures the item, walks the cycle through the source position,
// reduces repeat_count modulo the cycle length in the bit-serial remainder
// unit, walks that many steps again and publishes the result (or flags a
// bad table), with one table read per walk step on the single table port.
// A result waits in an output register while the next item is taken. The
// table is undefined until loaded.
// Depends on ppt_pkg, ppt_ctrl, ppt_datapath.
module permutation_power_transposer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ppt_pkg::SIZE_W-1:0]      csr_size_in_use,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [ppt_pkg::POS_W-1:0]       req_position,
   input  logic [ppt_pkg::POS_W-1:0]       req_target,
   input  logic [ppt_pkg::POS_W-1:0]       req_symbol,
   input  logic [ppt_pkg::COUNT_W-1:0]     req_repeat_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ppt_pkg::POS_W-1:0]       rsp_destination,
   output logic [ppt_pkg::POS_W-1:0]       rsp_symbol_out,
   output logic                            rsp_bad_table
);
   import ppt_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ppt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   ppt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_size_in_use  (csr_size_in_use),
      .req_action       (req_action),
      .req_position     (req_position),
      .req_target       (req_target),
      .req_symbol       (req_symbol),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_destination  (rsp_destination),
      .rsp_symbol_out   (rsp_symbol_out),
      .rsp_bad_table    (rsp_bad_table)
   );

endmodule

/* tb/ppt_placement_checker.sv */
// Scoreboard for the permutation power transposer: keeps its own copy of the
// permutation table and block size, predicts each placement and checks results.
// Depends on ppt_pkg.
module ppt_placement_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [ppt_pkg::SIZE_W-1:0]  csr_size_in_use,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_action,
   input  logic [ppt_pkg::POS_W-1:0]   req_position,
   input  logic [ppt_pkg::POS_W-1:0]   req_target,
   input  logic [ppt_pkg::POS_W-1:0]   req_symbol,
   input  logic [ppt_pkg::COUNT_W-1:0] req_repeat_count,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [ppt_pkg::POS_W-1:0]   rsp_destination,
   input  logic [ppt_pkg::POS_W-1:0]   rsp_symbol_out,
   input  logic                        rsp_bad_table,
   output int                          failures,
   output int                          outstanding
);
   import ppt_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0] destination;
      logic [POS_W-1:0] symbol_out;
      logic             bad_table;
   } placement_type;

   logic [POS_W-1:0]  perm_mirror [MAX_SIZE];
   logic [SIZE_W-1:0] size_mirror;
   placement_type     placements_due [$];
   int                mismatches;

   function automatic int unsigned block_size();
      if (size_mirror == 0) return 1;
      if (size_mirror > MAX_SIZE) return MAX_SIZE;
      return size_mirror;
   endfunction

   function automatic placement_type predict_placement(int unsigned pos,
                                                       logic [POS_W-1:0] sym,
                                                       int unsigned count);
      placement_type res;
      int unsigned   n, cur, len, steps;
      logic          done;
      n = block_size();
      res.destination = '0;
      res.symbol_out  = sym;
      res.bad_table   = 1'b0;
      if (pos >= n) begin
         res.bad_table = 1'b1;
      end else begin
         // cycle length through pos; a stray entry or no return marks the table bad
         cur  = pos;
         len  = 0;
         done = 1'b0;
         while (!done) begin
            cur = perm_mirror[cur];
            len++;
            if (cur >= n) begin
               res.bad_table = 1'b1;
               done = 1'b1;
            end else if (cur == pos) begin
               done = 1'b1;
            end else if (len >= n) begin
               res.bad_table = 1'b1;
               done = 1'b1;
            end
         end
         if (!res.bad_table) begin
            steps = count % len;
            cur   = pos;
            for (int unsigned i = 0; i < steps; i++) cur = perm_mirror[cur];
            res.destination = POS_W'(cur);
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      placement_type due;
      if (reset) begin
         size_mirror = SIZE_W'(MAX_SIZE);
         placements_due.delete();
         mismatches = 0;
         foreach (perm_mirror[i]) perm_mirror[i] = '0;
      end else begin
         if (csr_valid && csr_ready) size_mirror = csr_size_in_use;
         if (rsp_valid && rsp_ready) begin
            if (placements_due.size() == 0) begin
               $error("unexpected item: destination %0d symbol_out %0d bad_table %0d",
                      rsp_destination, rsp_symbol_out, rsp_bad_table);
               mismatches++;
            end else begin
               due = placements_due.pop_front();
               if (rsp_destination !== due.destination) begin
                  $error("destination: expected %0d, got %0d", due.destination,
                         rsp_destination);
                  mismatches++;
               end
               if (rsp_symbol_out !== due.symbol_out) begin
                  $error("symbol_out: expected %0d, got %0d", due.symbol_out,
                         rsp_symbol_out);
                  mismatches++;
               end
               if (rsp_bad_table !== due.bad_table) begin
                  $error("bad_table: expected %0d, got %0d", due.bad_table,
                         rsp_bad_table);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_action == ACT_LOAD) begin
               if (req_position < block_size()) perm_mirror[req_position] = req_target;
            end else begin
               placements_due.push_back(predict_placement(req_position, req_symbol,
                                                          req_repeat_count));
            end
         end
      end
      failures    <= mismatches;
      outstanding <= placements_due.size();
   end

endmodule

/* tb/permutation_power_transposer_tb.sv */
// Testbench top for the permutation power transposer: drives size writes,
// load and encode items and result back-pressure, and gives the verdict.
// Depends on ppt_pkg, ppt_placement_checker and permutation_power_transposer.
module permutation_power_transposer_tb;
   import ppt_pkg::*;

   localparam int NUM_PHASES    = 13;
   localparam int OPS_PER_PHASE = 40;
   localparam int HOLD_PHASE    = 3;
   localparam int HOLD_LEN      = 1500;
   localparam int SETTLE_CYCLES = 600;
   localparam int QUIET_LIMIT   = 10000;

   logic               clock;
   logic               reset            = 1'b1;
   logic               csr_valid        = 1'b0;
   logic               csr_ready;
   logic [SIZE_W-1:0]  csr_size_in_use  = '0;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic               req_action       = ACT_LOAD;
   logic [POS_W-1:0]   req_position     = '0;
   logic [POS_W-1:0]   req_target       = '0;
   logic [POS_W-1:0]   req_symbol       = '0;
   logic [COUNT_W-1:0] req_repeat_count = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic [POS_W-1:0]   rsp_destination;
   logic [POS_W-1:0]   rsp_symbol_out;
   logic               rsp_bad_table;

   int                 failures;
   int                 outstanding;
   int                 send_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   logic               rsp_hold      = 1'b0;
   int                 hold_count    = 0;
   logic [POS_W-1:0]   intended [MAX_SIZE];
   int                 phase_sizes [NUM_PHASES] =
                          '{0, 1, 2, 3, 5, 9, 16, 37, 64, 511, 256, 300, 12};

   permutation_power_transposer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_size_in_use  (csr_size_in_use),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_position     (req_position),
      .req_target       (req_target),
      .req_symbol       (req_symbol),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_destination  (rsp_destination),
      .rsp_symbol_out   (rsp_symbol_out),
      .rsp_bad_table    (rsp_bad_table)
   );

   ppt_placement_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_size_in_use  (csr_size_in_use),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_position     (req_position),
      .req_target       (req_target),
      .req_symbol       (req_symbol),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_destination  (rsp_destination),
      .rsp_symbol_out   (rsp_symbol_out),
      .rsp_bad_table    (rsp_bad_table),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: a bounded hold-off after rsp_hold goes up, random stalls otherwise
   always @(posedge clock) begin
      if (rsp_hold && hold_count < HOLD_LEN) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         if (!rsp_hold) hold_count <= 0;
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[permutation_power_transposer] ERROR");
      $finish;
   end

   task automatic send_item(input logic act, input logic [POS_W-1:0] pos,
                            input logic [POS_W-1:0] tgt, input logic [POS_W-1:0] sym,
                            input logic [COUNT_W-1:0] count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_position     <= pos;
      req_target       <= tgt;
      req_symbol       <= sym;
      req_repeat_count <= count;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic load_entry(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] tgt);
      send_item(ACT_LOAD, pos, tgt, POS_W'($urandom), COUNT_W'($urandom));
   endtask

   task automatic encode_symbol(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] sym,
                                input logic [COUNT_W-1:0] count);
      send_item(ACT_ENCODE, pos, POS_W'($urandom), sym, count);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] value);
      drain_results();
      // wait a settle time after the last result before writing the size
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_size_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic load_permutation(int unsigned n);
      int unsigned      j;
      logic [POS_W-1:0] t;
      for (int unsigned i = 0; i < n; i++) intended[i] = POS_W'(i);
      for (int unsigned i = n - 1; i > 0; i--) begin
         j           = $urandom_range(i);
         t           = intended[i];
         intended[i] = intended[j];
         intended[j] = t;
      end
      for (int unsigned i = 0; i < n; i++) load_entry(POS_W'(i), intended[i]);
   endtask

   function automatic logic [COUNT_W-1:0] pick_count(int unsigned n);
      case ($urandom_range(9))
         0:       return '0;
         1, 2, 3: return COUNT_W'($urandom);
         4:       return 31'h7FFF_FFFF - COUNT_W'($urandom_range(3 * n));
         default: return COUNT_W'($urandom_range(3 * n));
      endcase
   endfunction

   initial begin : stimulus
      logic [POS_W-1:0] first_perm [8];
      int unsigned      n, prev_n, a, b, pick;
      logic [POS_W-1:0] swap_tmp;
      first_perm = '{1, 2, 0, 4, 3, 5, 7, 6};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: cycles of length 3, 2, 1, 2 over eight positions
      write_size(9'd8);
      for (int i = 0; i < 8; i++) load_entry(POS_W'(i), first_perm[i]);
      encode_symbol(8'd0, 8'h00, 31'd0);
      encode_symbol(8'd0, 8'hFF, 31'h7FFF_FFFF);
      encode_symbol(8'd2, 8'h41, 31'd5);
      encode_symbol(8'd5, 8'h5A, 31'h4000_0000);
      encode_symbol(8'd7, 8'hA5, 31'd1);
      encode_symbol(8'd255, 8'h80, 31'd3);
      encode_symbol(8'd8, 8'h01, 31'd0);
      load_entry(8'd200, 8'd0);
      load_entry(8'd8, 8'hFF);
      encode_symbol(8'd4, 8'h7E, 31'd2);
      load_entry(8'd5, 8'd200);
      encode_symbol(8'd5, 8'h33, 31'd7);
      load_entry(8'd3, 8'd3);
      encode_symbol(8'd4, 8'h10, 31'd1);
      encode_symbol(8'd3, 8'h20, 31'd9);
      load_entry(8'd7, 8'd255);
      encode_symbol(8'd6, 8'hCC, 31'd1);
      prev_n = 8;

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p % 4)
            0: begin
               send_idle_pct <= 0;
               rsp_stall_pct <= 0;
            end
            1: begin
               send_idle_pct <= 76;
               rsp_stall_pct <= 0;
            end
            2: begin
               send_idle_pct <= 0;
               rsp_stall_pct <= 76;
            end
            default: begin
               send_idle_pct <= 8;
               rsp_stall_pct <= 8;
            end
         endcase
         write_size(SIZE_W'(phase_sizes[p]));
         n = (phase_sizes[p] == 0) ? 1 :
             (phase_sizes[p] > MAX_SIZE) ? MAX_SIZE : phase_sizes[p];
         if (n != prev_n) load_permutation(n);
         prev_n = n;

         if (p == HOLD_PHASE) begin
            rsp_hold <= 1'b1;
            repeat (12)
               encode_symbol(POS_W'($urandom_range(n - 1)), POS_W'($urandom), pick_count(n));
            drain_results();
            rsp_hold <= 1'b0;
         end

         repeat (OPS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 64) begin
               encode_symbol(POS_W'($urandom_range(n - 1)), POS_W'($urandom), pick_count(n));
            end else if (pick < 74) begin
               encode_symbol(POS_W'($urandom), POS_W'($urandom), pick_count(n));
            end else if (pick < 86) begin
               a           = $urandom_range(n - 1);
               b           = $urandom_range(n - 1);
               swap_tmp    = intended[a];
               intended[a] = intended[b];
               intended[b] = swap_tmp;
               load_entry(POS_W'(a), intended[a]);
               load_entry(POS_W'(b), intended[b]);
            end else if (pick < 95) begin
               // break one entry, encode one to three items, then put it back
               a = $urandom_range(n - 1);
               load_entry(POS_W'(a), POS_W'($urandom));
               repeat ($urandom_range(3, 1))
                  encode_symbol(POS_W'($urandom_range(n - 1)), POS_W'($urandom),
                                pick_count(n));
               load_entry(POS_W'(a), intended[a]);
            end else if (n < MAX_SIZE) begin
               load_entry(POS_W'($urandom_range(MAX_SIZE - 1, n)), POS_W'($urandom));
            end else begin
               encode_symbol(POS_W'($urandom), POS_W'($urandom), pick_count(n));
            end
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("[permutation_power_transposer] OK");
      else
         $display("[permutation_power_transposer] ERROR");
      $finish;
   end

endmodule
